// ===== src/assert_macros.svh =====
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion on clk_i, masked while rst_ni is low
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property that must never hold
`define ASSERT_NEVER(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);

`endif

// ===== src/dtocr_pkg.sv =====
// ----------------------------------------------------------------------------
// dtocr_pkg
// Shared types, glyph table and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package dtocr_pkg;

  localparam int unsigned GLYPH_COLS  = 5;
  localparam int unsigned GLYPH_ROWS  = 7;
  localparam int unsigned GLYPH_COUNT = 10;
  localparam int unsigned PIXEL_W     = 24;
  localparam int unsigned SIZE_W      = 7;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned SCORE_W     = 18;

  typedef logic [GLYPH_COLS-1:0] glyph_row_t;

  localparam glyph_row_t GLYPHS [GLYPH_COUNT][GLYPH_ROWS] = '{
    '{5'h1F, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1F},
    '{5'h1C, 5'h04, 5'h04, 5'h04, 5'h05, 5'h05, 5'h1F},
    '{5'h1F, 5'h01, 5'h01, 5'h1F, 5'h10, 5'h10, 5'h1F},
    '{5'h1F, 5'h01, 5'h01, 5'h0F, 5'h01, 5'h01, 5'h1F},
    '{5'h10, 5'h12, 5'h12, 5'h12, 5'h1F, 5'h02, 5'h02},
    '{5'h0F, 5'h08, 5'h08, 5'h0F, 5'h01, 5'h01, 5'h1F},
    '{5'h10, 5'h10, 5'h10, 5'h1F, 5'h11, 5'h11, 5'h1F},
    '{5'h1F, 5'h01, 5'h01, 5'h02, 5'h04, 5'h04, 5'h04},
    '{5'h0E, 5'h0A, 5'h0A, 5'h1F, 5'h11, 5'h11, 5'h1F},
    '{5'h1F, 5'h11, 5'h1F, 5'h01, 5'h01, 5'h01, 5'h01}
  };

  // Glyph cell lookup; templates beyond the table are empty
  function automatic logic glyph_bit(input logic [3:0] t, input logic [2:0] r,
                                     input logic [2:0] c);
    glyph_row_t row;
    row = '0;
    if (32'(t) < GLYPH_COUNT && 32'(r) < GLYPH_ROWS && 32'(c) < GLYPH_COLS) begin
      row = GLYPHS[t][r];
      return row[3'(GLYPH_COLS - 1) - c];
    end
    return 1'b0;
  endfunction

  typedef struct packed {
    logic accept;
    logic col_init;
    logic col_step;
    logic row_init;
    logic row_rd;
    logic row_chk;
    logic match_init;
    logic match;
    logic drain;
    logic pick;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic col_done;
    logic row_done;
    logic match_last;
    logic pick_done;
  } status_t;

endpackage

// ===== src/dtocr_ram.sv =====
// ----------------------------------------------------------------------------
// dtocr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dtocr_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== src/dtocr_ctrl.sv =====
// ----------------------------------------------------------------------------
// dtocr_ctrl
// Sequencer: pixel load, column scan, row scan, template match, pick, result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dtocr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              last_pixel_i,
  input  dtocr_pkg::status_t status_i,
  output dtocr_pkg::cmd_t    cmd_o,
  output logic              busy_o,
  output logic              done_o
);

  localparam logic [3:0] S_LOAD       = 4'd0;
  localparam logic [3:0] S_COL        = 4'd1;
  localparam logic [3:0] S_ROW_INIT   = 4'd2;
  localparam logic [3:0] S_ROW_RD     = 4'd3;
  localparam logic [3:0] S_ROW_CHK    = 4'd4;
  localparam logic [3:0] S_MATCH_INIT = 4'd5;
  localparam logic [3:0] S_MATCH      = 4'd6;
  localparam logic [3:0] S_DRAIN      = 4'd7;
  localparam logic [3:0] S_PICK       = 4'd8;
  localparam logic [3:0] S_DONE       = 4'd9;

  logic [3:0] state_q, state_d;
  logic       accept;

  assign busy_o = (state_q != S_LOAD);
  assign done_o = (state_q == S_DONE);
  assign accept = start_i && !busy_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_LOAD:       if (accept && last_pixel_i) state_d = S_COL;
      S_COL:        if (status_i.col_done) state_d = S_ROW_INIT;
      S_ROW_INIT:   state_d = S_ROW_RD;
      S_ROW_RD:     state_d = S_ROW_CHK;
      S_ROW_CHK:    state_d = status_i.row_done ? S_MATCH_INIT : S_ROW_RD;
      S_MATCH_INIT: state_d = S_MATCH;
      S_MATCH:      if (status_i.match_last) state_d = S_DRAIN;
      S_DRAIN:      state_d = S_PICK;
      S_PICK:       if (status_i.pick_done) state_d = S_DONE;
      S_DONE:       state_d = S_LOAD;
      default:      state_d = S_LOAD;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.accept     = accept;
    cmd_o.col_init   = accept && last_pixel_i;
    cmd_o.col_step   = (state_q == S_COL);
    cmd_o.row_init   = (state_q == S_ROW_INIT);
    cmd_o.row_rd     = (state_q == S_ROW_RD);
    cmd_o.row_chk    = (state_q == S_ROW_CHK);
    cmd_o.match_init = (state_q == S_MATCH_INIT);
    cmd_o.match      = (state_q == S_MATCH);
    cmd_o.drain      = (state_q == S_DRAIN);
    cmd_o.pick       = (state_q == S_PICK);
    cmd_o.finish     = (state_q == S_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  `ASSERT_CLK(a_last_goes_busy, accept && last_pixel_i |=> busy_o, "no busy after last pixel")
  `ASSERT_CLK(a_done_single, done_o |=> !done_o, "result strobe longer than one cycle")
  `ASSERT_NEVER(a_done_idle, done_o && !busy_o, "result while idle")

endmodule

// ===== src/dtocr_datapath.sv =====
// ----------------------------------------------------------------------------
// dtocr_datapath
// Ink store, column flags, crop bounds, scaled overlap counters and argmax.
// ----------------------------------------------------------------------------
module dtocr_datapath #(
  parameter int unsigned MAX_WIDTH     = 64,
  parameter int unsigned MAX_HEIGHT    = 64,
  parameter int unsigned NUM_TEMPLATES = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dtocr_pkg::cmd_t                   cmd_i,
  input  logic [dtocr_pkg::PIXEL_W-1:0]     pixel_i,
  input  logic [dtocr_pkg::SIZE_W-1:0]      img_width_i,
  input  logic [dtocr_pkg::SIZE_W-1:0]      img_height_i,
  output dtocr_pkg::status_t                status_o,
  output logic [dtocr_pkg::DIGIT_W-1:0]     digit_o,
  output logic [dtocr_pkg::SCORE_W-1:0]     score_o
);

  localparam int unsigned XW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned YW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned XI    = MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned TW    = NUM_TEMPLATES > 1 ? $clog2(NUM_TEMPLATES) : 1;
  localparam int unsigned SW    = $clog2(35 * DEPTH + 1);
  localparam logic [2:0]  MX_LAST = 3'(dtocr_pkg::GLYPH_COLS - 1);
  localparam logic [2:0]  MY_LAST = 3'(dtocr_pkg::GLYPH_ROWS - 1);

  // Load side
  logic [CW-1:0]        count_q;
  logic [XW-1:0]        held_w_q, w_eff, w_clamp;
  logic [YW-1:0]        held_h_q, h_eff, h_clamp;
  logic [XW-1:0]        col_q, col_idx;
  logic [MAX_WIDTH-1:0] cink_q;
  logic [CW-1:0]        area;
  logic                 first, store, ink_in;
  logic [8:0]           w_ext, h_ext;

  // Scan side
  logic [XW-1:0] left_q, right_q, x_q;
  logic [YW-1:0] top_q, bottom_q, y_q;
  logic          found_q, has_q, rd_ok_q, cbit, has_now, ink_rd;

  // Match side
  logic [XW-1:0] qx_q, cxc_q, cwm1;
  logic [YW-1:0] qy_q, cyc_q, chm1;
  logic [2:0]    mx_q, my_q, rx_q, ry_q;
  logic          x_end, y_end, p_valid_q;
  logic [NUM_TEMPLATES-1:0] p_g_q;
  logic [SW-1:0] score_q [NUM_TEMPLATES];

  // Pick
  logic [TW-1:0] t_q;
  logic [SW-1:0] best_q;
  logic [dtocr_pkg::DIGIT_W-1:0] best_digit_q;

  // RAM
  logic [YW-1:0] rd_row;
  logic [XW-1:0] rd_col;
  logic [CW-1:0] lin;
  logic [0:0]    rdata;

  assign w_ext   = {2'b00, img_width_i};
  assign h_ext   = {2'b00, img_height_i};
  assign w_clamp = (w_ext == 9'd0) ? XW'(1) :
                   (w_ext > 9'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : XW'(w_ext);
  assign h_clamp = (h_ext == 9'd0) ? YW'(1) :
                   (h_ext > 9'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT) : YW'(h_ext);
  assign first   = (count_q == '0);
  assign w_eff   = first ? w_clamp : held_w_q;
  assign h_eff   = first ? h_clamp : held_h_q;
  assign area    = CW'(CW'(w_eff) * CW'(h_eff));
  assign store   = cmd_i.accept && (count_q < area);
  assign ink_in  = (pixel_i == '0);
  assign col_idx = first ? '0 : col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      held_w_q <= '0;
      held_h_q <= '0;
      col_q    <= '0;
      cink_q   <= '0;
    end else if (cmd_i.finish) begin
      count_q <= '0;
      cink_q  <= '0;
    end else if (cmd_i.accept) begin
      held_w_q <= w_eff;
      held_h_q <= h_eff;
      if (store) begin
        count_q <= count_q + CW'(1);
        col_q   <= (col_idx == w_eff - XW'(1)) ? '0 : col_idx + XW'(1);
        if (ink_in) cink_q[col_idx[XI-1:0]] <= 1'b1;
      end
    end
  end

  // Read address: row scan walks (y, x), match walks the crop cells
  assign rd_row = cmd_i.match ? top_q + qy_q : y_q;
  assign rd_col = cmd_i.match ? left_q + qx_q : x_q;
  assign lin    = CW'(CW'(rd_row) * CW'(held_w_q)) + CW'(rd_col);

  dtocr_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_ink_store (
    .clk_i   (clk_i),
    .we_i    (store),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (ink_in),
    .raddr_i (lin[AW-1:0]),
    .rdata_o (rdata)
  );

  assign ink_rd  = rd_ok_q && rdata[0];
  assign cbit    = cink_q[x_q[XI-1:0]];
  assign has_now = has_q || ink_rd;
  assign cwm1    = right_q - left_q;
  assign chm1    = bottom_q - top_q;
  assign x_end   = (qx_q == cwm1) && (mx_q == MX_LAST);
  assign y_end   = (qy_q == chm1) && (my_q == MY_LAST);

  assign status_o.col_done   = (found_q && !cbit) || (x_q == held_w_q - XW'(1));
  assign status_o.row_done   = (x_q == right_q) &&
                               ((found_q && !has_now) || (y_q == held_h_q - YW'(1)));
  assign status_o.match_last = x_end && y_end;
  assign status_o.pick_done  = (32'(t_q) == NUM_TEMPLATES - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      right_q  <= '0;
      top_q    <= '0;
      bottom_q <= '0;
      x_q      <= '0;
      y_q      <= '0;
      found_q  <= 1'b0;
      has_q    <= 1'b0;
      rd_ok_q  <= 1'b0;
    end else begin
      rd_ok_q <= (cmd_i.row_rd || cmd_i.match) && (lin < count_q);
      if (cmd_i.col_init) begin
        x_q      <= '0;
        found_q  <= 1'b0;
        left_q   <= '0;
        right_q  <= w_eff - XW'(1);
        top_q    <= '0;
        bottom_q <= h_eff - YW'(1);
      end else if (cmd_i.col_step) begin
        if (!found_q && cbit) begin
          left_q  <= x_q;
          found_q <= 1'b1;
        end else if (found_q && !cbit) begin
          right_q <= x_q - XW'(1);
        end
        x_q <= x_q + XW'(1);
      end else if (cmd_i.row_init) begin
        y_q     <= '0;
        x_q     <= left_q;
        found_q <= 1'b0;
        has_q   <= 1'b0;
      end else if (cmd_i.row_chk) begin
        if (x_q == right_q) begin
          if (!found_q && has_now) begin
            top_q   <= y_q;
            found_q <= 1'b1;
          end else if (found_q && !has_now) begin
            bottom_q <= y_q - YW'(1);
          end
          y_q   <= y_q + YW'(1);
          x_q   <= left_q;
          has_q <= 1'b0;
        end else begin
          x_q   <= x_q + XW'(1);
          has_q <= has_now;
        end
      end
    end
  end

  // Scaled grid walk: q = crop cell (xx/5, yy/7), r = glyph cell (xx/cw, yy/ch)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qx_q <= '0; mx_q <= '0; cxc_q <= '0; rx_q <= '0;
      qy_q <= '0; my_q <= '0; cyc_q <= '0; ry_q <= '0;
      p_valid_q <= 1'b0;
    end else begin
      p_valid_q <= cmd_i.match;
      if (cmd_i.match_init) begin
        qx_q <= '0; mx_q <= '0; cxc_q <= '0; rx_q <= '0;
        qy_q <= '0; my_q <= '0; cyc_q <= '0; ry_q <= '0;
      end else if (cmd_i.match) begin
        if (x_end) begin
          qx_q <= '0; mx_q <= '0; cxc_q <= '0; rx_q <= '0;
          if (my_q == MY_LAST) begin
            my_q <= '0;
            qy_q <= qy_q + YW'(1);
          end else begin
            my_q <= my_q + 3'd1;
          end
          if (cyc_q == chm1) begin
            cyc_q <= '0;
            ry_q  <= ry_q + 3'd1;
          end else begin
            cyc_q <= cyc_q + YW'(1);
          end
        end else begin
          if (mx_q == MX_LAST) begin
            mx_q <= '0;
            qx_q <= qx_q + XW'(1);
          end else begin
            mx_q <= mx_q + 3'd1;
          end
          if (cxc_q == cwm1) begin
            cxc_q <= '0;
            rx_q  <= rx_q + 3'd1;
          end else begin
            cxc_q <= cxc_q + XW'(1);
          end
        end
      end
    end
  end

  for (genvar t = 0; t < NUM_TEMPLATES; t++) begin : g_tmpl
    always_ff @(posedge clk_i) begin
      p_g_q[t] <= dtocr_pkg::glyph_bit(4'(t), ry_q, rx_q);
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        score_q[t] <= '0;
      end else if (cmd_i.match_init) begin
        score_q[t] <= '0;
      end else if (p_valid_q && ink_rd && p_g_q[t]) begin
        score_q[t] <= score_q[t] + SW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_q          <= '0;
      best_q       <= '0;
      best_digit_q <= '0;
    end else if (cmd_i.drain) begin
      t_q <= '0;
    end else if (cmd_i.pick) begin
      if (t_q == '0 || score_q[t_q] > best_q) begin
        best_q       <= score_q[t_q];
        best_digit_q <= dtocr_pkg::DIGIT_W'(t_q);
      end
      t_q <= t_q + TW'(1);
    end
  end

  assign digit_o = best_digit_q;
  assign score_o = dtocr_pkg::SCORE_W'(best_q);

endmodule

// ===== src/digit_template_ocr_unit.sv =====
// ----------------------------------------------------------------------------
// digit_template_ocr_unit
// Single-digit recogniser by 5x7 template overlap on a cropped ink image.
// ----------------------------------------------------------------------------
// Pixels are taken one per cycle while busy_o is low; zero is ink. The pixel
// with last_pixel_i set starts recognition and busy_o rises until the result.
// Recognition runs from the ink store (one read port): a column scan, a row scan
// over the pixels of the crop's row band (rows tested until the band ends),
// scaled-grid matching over 35*cw*ch grid cells (all templates in parallel)
// and an argmax over the NUM_TEMPLATES scores.
// done_o pulses for one cycle with digit_o and score_o; the receiver cannot
// stall it, so it must capture the result in that cycle.
module digit_template_ocr_unit #(
  parameter int unsigned MAX_WIDTH     = 64,
  parameter int unsigned MAX_HEIGHT    = 64,
  parameter int unsigned NUM_TEMPLATES = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [dtocr_pkg::PIXEL_W-1:0] pixel_i,
  input  logic [dtocr_pkg::SIZE_W-1:0]  img_width_i,
  input  logic [dtocr_pkg::SIZE_W-1:0]  img_height_i,
  input  logic                          last_pixel_i,
  output logic                          done_o,
  output logic [dtocr_pkg::DIGIT_W-1:0] digit_o,
  output logic [dtocr_pkg::SCORE_W-1:0] score_o
);

  dtocr_pkg::cmd_t    cmd;
  dtocr_pkg::status_t status;

  dtocr_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .last_pixel_i (last_pixel_i),
    .status_i     (status),
    .cmd_o        (cmd),
    .busy_o       (busy_o),
    .done_o       (done_o)
  );

  dtocr_datapath #(
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_HEIGHT    (MAX_HEIGHT),
    .NUM_TEMPLATES (NUM_TEMPLATES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .pixel_i      (pixel_i),
    .img_width_i  (img_width_i),
    .img_height_i (img_height_i),
    .status_o     (status),
    .digit_o      (digit_o),
    .score_o      (score_o)
  );

endmodule
